### hdl/ecal_pkg.sv
// shared types, constants and microcode table for the epoch to calendar converter
package ecal_pkg;

  localparam int STEP_W = 6;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
  localparam logic [7:0]  BASE_YEAR     = 8'd70;
  localparam logic [7:0]  NONLEAP_CENT  = 8'd200;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // program layout
  localparam logic [STEP_W-1:0] S_DAYS      = 6'd0;
  localparam logic [STEP_W-1:0] S_SAVE_DAYS = 6'd16;
  localparam logic [STEP_W-1:0] S_HOUR      = 6'd17;
  localparam logic [STEP_W-1:0] S_SAVE_HOUR = 6'd22;
  localparam logic [STEP_W-1:0] S_MIN       = 6'd23;
  localparam logic [STEP_W-1:0] S_SAVE_MIN  = 6'd29;
  localparam logic [STEP_W-1:0] S_WDAY      = 6'd30;
  localparam logic [STEP_W-1:0] S_SAVE_WDAY = 6'd43;
  localparam logic [STEP_W-1:0] S_YEAR      = 6'd44;
  localparam logic [STEP_W-1:0] S_SAVE_YDAY = 6'd45;
  localparam logic [STEP_W-1:0] S_MONTH     = 6'd46;
  localparam logic [STEP_W-1:0] S_DONE      = 6'd47;

  typedef enum logic [3:0] {
    OP_DIV       = 4'd0,
    OP_SAVE_DAYS = 4'd1,
    OP_SAVE_HOUR = 4'd2,
    OP_SAVE_MIN  = 4'd3,
    OP_SAVE_WDAY = 4'd4,
    OP_YEAR      = 4'd5,
    OP_SAVE_YDAY = 4'd6,
    OP_MONTH     = 4'd7,
    OP_DONE      = 4'd8
  } ecal_op_t;

  typedef struct packed {
    ecal_op_t    op;
    logic        hold;
    logic [31:0] k;
  } ecal_word_t;

  typedef struct packed {
    logic       run;
    ecal_word_t word;
  } ecal_ctrl_t;

  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != NONLEAP_CENT);
  endfunction

  function automatic logic [8:0] month_len(input logic leap, input logic [3:0] m);
    logic [8:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 9'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 9'd30;
      4'd1:                                       len = leap ? 9'd29 : 9'd28;
      default:                                    len = 9'd31;
    endcase
    return len;
  endfunction

  // microcode rom
  function automatic ecal_word_t ucode(input logic [STEP_W-1:0] pc);
    ecal_word_t w;
    logic [STEP_W-1:0] sh;
    w.op   = OP_DONE;
    w.hold = 1'b0;
    w.k    = '0;
    sh     = '0;
    if (pc < S_SAVE_DAYS) begin
      sh   = (S_SAVE_DAYS - 6'd1) - pc;
      w.op = OP_DIV;
      w.k  = SECS_PER_DAY << sh;
    end else if (pc == S_SAVE_DAYS) begin
      w.op = OP_SAVE_DAYS;
    end else if (pc < S_SAVE_HOUR) begin
      sh   = (S_SAVE_HOUR - 6'd1) - pc;
      w.op = OP_DIV;
      w.k  = SECS_PER_HOUR << sh;
    end else if (pc == S_SAVE_HOUR) begin
      w.op = OP_SAVE_HOUR;
    end else if (pc < S_SAVE_MIN) begin
      sh   = (S_SAVE_MIN - 6'd1) - pc;
      w.op = OP_DIV;
      w.k  = SECS_PER_MIN << sh;
    end else if (pc == S_SAVE_MIN) begin
      w.op = OP_SAVE_MIN;
    end else if (pc < S_SAVE_WDAY) begin
      sh   = (S_SAVE_WDAY - 6'd1) - pc;
      w.op = OP_DIV;
      w.k  = DAYS_PER_WEEK << sh;
    end else if (pc == S_SAVE_WDAY) begin
      w.op = OP_SAVE_WDAY;
    end else if (pc == S_YEAR) begin
      w.op   = OP_YEAR;
      w.hold = 1'b1;
    end else if (pc == S_SAVE_YDAY) begin
      w.op = OP_SAVE_YDAY;
    end else if (pc == S_MONTH) begin
      w.op   = OP_MONTH;
      w.hold = 1'b1;
    end else begin
      w.op = OP_DONE;
    end
    return w;
  endfunction

endpackage

### hdl/ecal_seq.sv
// microcode sequencer: step counter, rom and conditional repeat
module ecal_seq import ecal_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       take,
  output logic       busy,
  output ecal_ctrl_t ctrl
);

  logic [STEP_W-1:0] pc;
  ecal_word_t        word;

  assign word      = ucode(pc);
  assign ctrl.run  = busy;
  assign ctrl.word = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= S_DAYS;
      end
    end else if (word.op == OP_DONE) begin
      busy <= 1'b0;
    end else if (!(word.hold && take)) begin
      pc <= pc + 6'd1;
    end
  end

endmodule

### hdl/epoch_seconds_to_calendar.sv
// epoch_seconds_to_calendar: unix seconds to utc calendar fields
// busy covers the division and save steps, one year-loop step per full year past 1970
//   and one month-loop step per whole month in the year, with done high in the cycle
//   right after the last busy cycle; a new request is taken only while busy is low,
//   as the shared compare/subtract unit also steps the year loop once per year
// reset: rst clears the sequencer and done; result registers are not reset
module epoch_seconds_to_calendar import ecal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  output logic        busy,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month
);

  ecal_ctrl_t  ctrl;
  logic        take;
  logic [31:0] acc;
  logic [15:0] q;
  logic [15:0] days;
  logic [31:0] b;
  logic [31:0] diff;
  logic        geq;
  logic        leap;

  ecal_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .take  (take),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  assign leap = is_leap(years_since_1900);

  always_comb begin
    case (ctrl.word.op)
      OP_YEAR:  b = leap ? 32'd366 : 32'd365;
      OP_MONTH: b = {23'd0, month_len(leap, month_index)};
      default:  b = ctrl.word.k;
    endcase
  end

  assign geq  = acc >= b;
  assign diff = acc - b;

  always_comb begin
    case (ctrl.word.op)
      OP_DIV, OP_YEAR: take = ctrl.run && geq;
      OP_MONTH:        take = ctrl.run && geq && (month_index != LAST_MONTH);
      default:         take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.run && (ctrl.word.op == OP_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= epoch_seconds;
      q   <= '0;
    end else if (ctrl.run) begin
      case (ctrl.word.op)
        OP_DIV: begin
          if (take) begin
            acc <= diff;
          end
          q <= {q[14:0], take};
        end
        OP_SAVE_DAYS: begin
          days <= q;
          q    <= '0;
        end
        OP_SAVE_HOUR: begin
          hour <= q[4:0];
          q    <= '0;
        end
        OP_SAVE_MIN: begin
          minute <= q[5:0];
          second <= acc[5:0];
          acc    <= {16'd0, days} + 32'd4;
        end
        OP_SAVE_WDAY: begin
          weekday          <= acc[2:0];
          acc              <= {16'd0, days};
          years_since_1900 <= BASE_YEAR;
        end
        OP_YEAR: begin
          if (take) begin
            acc              <= diff;
            years_since_1900 <= years_since_1900 + 8'd1;
          end
        end
        OP_SAVE_YDAY: begin
          day_of_year <= acc[8:0];
          month_index <= '0;
        end
        OP_MONTH: begin
          if (take) begin
            acc         <= diff;
            month_index <= month_index + 4'd1;
          end
        end
        OP_DONE: begin
          day_of_month <= acc[4:0] + 5'd1;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done without a finished request");

  a_start_accepted: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_index <= LAST_MONTH && day_of_month != 5'd0 &&
              day_of_year <= 9'd365))
    else $error("date out of range");

endmodule
